### rtl/bcu_pkg.sv
// Shared types and constants for the binomial coefficient unit.
// No dependencies.
`default_nettype none
package bcu_pkg;

    localparam int unsigned FieldW = 31;
    localparam int unsigned Steps  = 16;
    localparam int unsigned MW     = 5;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_BADARG   = 2'd2
    } status_t;

    typedef struct packed {
        logic [FieldW-1:0] base;
        logic [MW-1:0]     m;
        logic [FieldW-1:0] acc;
        status_t           status;
    } bcu_item_t;

    function automatic int unsigned tz_count(input int unsigned d);
        int unsigned k;
        int unsigned v;
        k = 0;
        v = d;
        for (int j = 0; j < 5; j++)
        begin
            if (v[0] == 1'b0)
            begin
                v = v >> 1;
                k = k + 1;
            end
        end
        return k;
    endfunction

    // inverse of the odd part of d modulo 2^32
    function automatic logic [31:0] odd_inverse(input int unsigned d);
        logic [31:0] o;
        logic [31:0] x;
        o = 32'(d) >> tz_count(d);
        x = o;
        for (int j = 0; j < 5; j++)
        begin
            x = x * (32'd2 - o * x);
        end
        return x;
    endfunction

endpackage
`default_nettype wire

### rtl/bcu_in_if.sv
// Request channel of the binomial coefficient unit.
// No dependencies.
`default_nettype none
interface bcu_in_if;
    logic        valid;
    logic        ready;
    logic [30:0] n_total;
    logic [30:0] k_chosen;
    modport source (output valid, n_total, k_chosen, input ready);
    modport sink (input valid, n_total, k_chosen, output ready);
endinterface
`default_nettype wire

### rtl/bcu_out_if.sv
// Result channel of the binomial coefficient unit.
// No dependencies.
`default_nettype none
interface bcu_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] coefficient;
    logic [1:0]  status;
    modport source (output valid, coefficient, status, input ready);
    modport sink (input valid, coefficient, status, output ready);
endinterface
`default_nettype wire

### rtl/binomial_coefficient_unit.sv
// Binomial coefficient unit: setup register, chain of 16 step cells, output register.
// The setup register loads on the accepting edge; the item then passes through the
// a and b registers of each cell in turn, and the output register follows the last cell.
// Throughput: one item per cycle; the whole chain advances when the output is free.
// Each cell holds one multiplier and one exact divide by its own constant index.
// Reset (rst_n, asynchronous, active low) clears all valid bits.
// Depends on bcu_pkg, bcu_in_if, bcu_out_if, bcu_cell.
`default_nettype none
module binomial_coefficient_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bcu_in_if.sink     in_ch,
    bcu_out_if.source  out_ch
);
    import bcu_pkg::*;

    logic              en;
    logic              s_valid_reg;
    bcu_item_t         s_item_reg;
    bcu_item_t         s_next;
    logic [FieldW-1:0] mr;
    logic              o_valid_reg;
    logic [FieldW-1:0] o_coef_reg;
    status_t           o_status_reg;

    logic              chain_valid [0:Steps];
    bcu_item_t         chain_item  [0:Steps];

    assign en          = !o_valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    always_comb
    begin
        s_next = '0;
        mr = (in_ch.k_chosen > (in_ch.n_total >> 1)) ? (in_ch.n_total - in_ch.k_chosen)
                                                      : in_ch.k_chosen;
        s_next.acc  = FieldW'(1);
        s_next.base = in_ch.n_total - mr;
        s_next.m    = MW'(mr);
        if (in_ch.k_chosen > in_ch.n_total)
            s_next.status = ST_BADARG;
        else if (mr > FieldW'(Steps))
            s_next.status = ST_OVERFLOW;
        else
            s_next.status = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s_valid_reg <= in_ch.valid;
            o_valid_reg <= chain_valid[Steps];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_item_reg   <= s_next;
            o_status_reg <= chain_item[Steps].status;
            o_coef_reg   <= (chain_item[Steps].status == ST_OK) ? chain_item[Steps].acc : '0;
        end
    end

    assign chain_valid[0] = s_valid_reg;
    assign chain_item[0]  = s_item_reg;

    for (genvar g = 1; g <= Steps; g++)
    begin : g_cell
        bcu_cell #(.IDX(g)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .valid   (chain_valid[g-1]),
            .item    (chain_item[g-1]),
            .valid_q (chain_valid[g]),
            .item_q  (chain_item[g])
        );
    end

    assign out_ch.valid       = o_valid_reg;
    assign out_ch.coefficient = o_coef_reg;
    assign out_ch.status      = o_status_reg;
endmodule
`default_nettype wire

### rtl/bcu_cell.sv
// One multiply / exact-divide step: acc = acc * (base + IDX) / IDX.
// Depends on bcu_pkg.
`default_nettype none
module bcu_cell #(
    parameter int unsigned IDX = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              valid,
    input  wire bcu_pkg::bcu_item_t item,
    output logic                   valid_q,
    output bcu_pkg::bcu_item_t     item_q
);
    import bcu_pkg::*;

    localparam int unsigned Shift = tz_count(IDX);
    localparam logic [31:0] Inv   = odd_inverse(IDX);
    localparam logic [61:0] Limit = 62'(IDX) << 31;

    logic              a_valid_reg;
    bcu_item_t         a_item_reg;
    logic [61:0]       a_prod_reg;
    logic [61:0]       prod_next;
    logic [FieldW-1:0] factor;
    logic [61:0]       prod_sh;
    logic [31:0]       quot;
    logic              active;
    bcu_item_t         b_next;
    logic              b_valid_reg;
    bcu_item_t         b_item_reg;

    assign factor    = item.base + FieldW'(IDX);
    assign prod_next = 62'(item.acc) * 62'(factor);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_item_reg <= item;
            a_prod_reg <= prod_next;
            b_item_reg <= b_next;
        end
    end

    assign prod_sh = a_prod_reg >> Shift;
    assign quot    = prod_sh[31:0] * Inv;
    assign active  = (a_item_reg.status == ST_OK) && (32'(a_item_reg.m) >= IDX);

    always_comb
    begin
        b_next = a_item_reg;
        if (active)
        begin
            if (a_prod_reg >= Limit)
                b_next.status = ST_OVERFLOW;
            else
                b_next.acc = quot[FieldW-1:0];
        end
    end

    assign valid_q = b_valid_reg;
    assign item_q  = b_item_reg;
endmodule
`default_nettype wire

### rtl/bcu_checker.sv
// Port-level checks for the binomial coefficient unit, bound to the top level.
// Depends on bcu_pkg and binomial_coefficient_unit.
`default_nettype none
module bcu_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [30:0] coefficient,
    input wire logic [1:0]  status
);
    import bcu_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(coefficient) && $stable(status))
        else $error("result changed while stalled");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_BADARG)
        else $error("undefined status");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> coefficient == '0)
        else $error("error result with nonzero coefficient");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output state");
endmodule

bind binomial_coefficient_unit bcu_checker u_bcu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .coefficient (out_ch.coefficient),
    .status      (out_ch.status)
);
`default_nettype wire

### verif/bcu_checker.sv
// Checker for the binomial coefficient unit: watches both channels, predicts C(n,m)
// and status for each accepted request item and compares in order. Depends on bcu_pkg.
`timescale 1ns / 1ps
module bcu_scoreboard (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    input  wire logic        req_ready,
    input  wire logic [30:0] req_n,
    input  wire logic [30:0] req_k,
    input  wire logic        res_valid,
    input  wire logic        res_ready,
    input  wire logic [30:0] res_coef,
    input  wire logic [1:0]  res_status,
    output int               fail_count,
    output int               pending
);
    import bcu_pkg::*;

    typedef struct packed {
        logic [30:0] coef;
        status_t     status;
    } binom_res_t;

    binom_res_t coef_queue[$];

    function automatic binom_res_t binom_predict(input logic [30:0] n, input logic [30:0] k);
        binom_res_t r;
        logic [63:0] acc;
        logic [30:0] m;
        logic [30:0] base;
        r.coef = '0;
        if (k > n)
        begin
            r.status = ST_BADARG;
            return r;
        end
        m = (k > (n >> 1)) ? n - k : k;
        if (m > 31'd16)
        begin
            r.status = ST_OVERFLOW;
            return r;
        end
        base = n - m;
        acc = 64'd1;
        for (int i = 1; i <= m; i++)
        begin
            acc = acc * (64'(base) + 64'(i)) / 64'(i);
            if (acc > 64'd2147483647)
            begin
                r.status = ST_OVERFLOW;
                return r;
            end
        end
        r.coef = acc[30:0];
        r.status = ST_OK;
        return r;
    endfunction

    always @(posedge clk)
    begin
        binom_res_t exp_r;
        if (!rst_n)
        begin
            fail_count = 0;
            pending = 0;
            coef_queue.delete();
        end
        else
        begin
            if (req_valid && req_ready)
                coef_queue.push_back(binom_predict(req_n, req_k));
            if (res_valid && res_ready)
            begin
                if (coef_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result item: coef %0d status %0d",
                                 res_coef, res_status);
                end
                else
                begin
                    exp_r = coef_queue.pop_front();
                    if (exp_r.coef !== res_coef || exp_r.status !== res_status)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected coef %0d status %0d, got %0d %0d",
                                     exp_r.coef, exp_r.status, res_coef, res_status);
                    end
                end
            end
            pending = coef_queue.size();
        end
    end

endmodule

### verif/tb_top.sv
// Top of the binomial coefficient unit testbench: clock, reset, request stimulus and
// result back-pressure. Depends on bcu_pkg, bcu_in_if, bcu_out_if, bcu_scoreboard.
`timescale 1ns / 1ps
module tb_top;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycles = 0;

    bcu_in_if  in_ch ();
    bcu_out_if out_ch ();

    binomial_coefficient_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    bcu_scoreboard u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (in_ch.valid),
        .req_ready  (in_ch.ready),
        .req_n      (in_ch.n_total),
        .req_k      (in_ch.k_chosen),
        .res_valid  (out_ch.valid),
        .res_ready  (out_ch.ready),
        .res_coef   (out_ch.coefficient),
        .res_status (out_ch.status),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45)
            return 0;
        else if (p < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    task automatic send_item(input logic [30:0] n, input logic [30:0] k);
        int g;
        g = gap_len();
        repeat (g)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.n_total  <= n;
        in_ch.k_chosen <= k;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // random request shaped around the interesting regions
    task automatic send_random();
        logic [30:0] n;
        logic [30:0] k;
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1:
            begin
                n = 31'($urandom_range(0, 70));
                k = 31'($urandom_range(0, 72));
            end
            2, 3:
            begin
                n = 31'($urandom());
                k = 31'($urandom_range(0, 18));
                if ($urandom_range(0, 1))
                    k = n - k;
            end
            4:
            begin
                n = 31'($urandom_range(65500, 65600));
                k = $urandom_range(0, 1) ? 31'd2 : n - 31'd2;
            end
            5, 6:
            begin
                n = 31'($urandom_range(0, 2000));
                k = 31'($urandom_range(0, 17));
                if ($urandom_range(0, 1))
                    k = n - k;
            end
            7:
            begin
                n = 31'($urandom_range(30, 40));
                k = 31'($urandom_range(0, n));
            end
            default:
            begin
                n = 31'($urandom());
                k = 31'($urandom());
            end
        endcase
        send_item(n, k);
    endtask

    always @(negedge clk)
    begin
        int p;
        p = $urandom_range(0, 99);
        if (cycles % 3000 < 500)
            out_ch.ready <= 1'b1;
        else if (p < 65)
            out_ch.ready <= 1'b1;
        else if (p < 97)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(0, 7) == 0);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.n_total  = '0;
        in_ch.k_chosen = '0;
        out_ch.ready   = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_item(31'd0, 31'd0);
        send_item(31'd0, 31'd1);
        send_item(31'h7FFFFFFF, 31'd0);
        send_item(31'h7FFFFFFF, 31'd1);
        send_item(31'h7FFFFFFF, 31'h7FFFFFFF);
        send_item(31'h7FFFFFFF, 31'h7FFFFFFE);
        send_item(31'd0, 31'h7FFFFFFF);
        send_item(31'h7FFFFFFE, 31'h7FFFFFFF);
        send_item(31'd65536, 31'd2);
        send_item(31'd65537, 31'd2);
        send_item(31'd65537, 31'd65535);
        send_item(31'd33, 31'd16);
        send_item(31'd34, 31'd17);
        send_item(31'd33, 31'd17);
        send_item(31'd10, 31'd5);
        send_item(31'd35, 31'd16);
        send_item(31'd1000, 31'd500);
        send_item(31'h55555555, 31'h2AAAAAAA);
        send_item(31'h2AAAAAAA, 31'h55555555);
        send_item(31'd1, 31'd1);

        repeat (2000)
            send_random();
        in_ch.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
